/* rtl/swrl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding-window rate limiter package
// Field widths, configuration register indexes and reset values shared by
// the rate limiter core.
// ----------------------------------------------------------------------------
package swrl_pkg;

    // Default structural parameters of the core.
    localparam int unsigned FLOWS_DEF     = 64;
    localparam int unsigned LOG_DEPTH_DEF = 16;
    localparam int unsigned TIME_BITS_DEF = 48;

    // Fixed field widths.
    localparam int unsigned FLOW_W     = 6;
    localparam int unsigned LIMIT_W    = 5;
    localparam int unsigned WIN_W      = 36;
    localparam int unsigned REM_W      = 5;
    localparam int unsigned RETRY_W    = 36;
    localparam int unsigned CFG_DATA_W = 36;
    localparam int unsigned CFG_IDX_W  = 1;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Configuration register indexes.
    localparam cfg_idx_t REG_REQUEST_LIMIT = 1'b0;
    localparam cfg_idx_t REG_WINDOW_LENGTH = 1'b1;

    // Register reset values.
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 5'd10;
    localparam logic [WIN_W-1:0]   WIN_RST   = 36'd60000000;

    // Saturation value of the retry delay.
    localparam logic [WIN_W-1:0]   WIN_MAX   = '1;

endpackage

/* rtl/swrl_stamp_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timestamp log memory
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module swrl_stamp_ram #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned WIDTH = 48
) (
    input  logic                                         clk,
    input  logic                                         rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                             rd_data,
    input  logic                                         wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                             wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/swrl_flow_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-flow ring state table
// Holds the ring head and entry count of every flow in a synchronous RAM and
// sweeps it to zero after reset, one entry per cycle.
// ----------------------------------------------------------------------------
module swrl_flow_table #(
    parameter int unsigned FLOWS   = 64,
    parameter int unsigned ENTRY_W = 9
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         rd_en,
    input  logic [((FLOWS > 1) ? $clog2(FLOWS) : 1)-1:0] rd_addr,
    output logic [ENTRY_W-1:0]                           rd_data,
    input  logic                                         wr_en,
    input  logic [((FLOWS > 1) ? $clog2(FLOWS) : 1)-1:0] wr_addr,
    input  logic [ENTRY_W-1:0]                           wr_data,
    output logic                                         init_done
);

    localparam int unsigned AW = (FLOWS > 1) ? $clog2(FLOWS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(FLOWS - 1);

    logic [ENTRY_W-1:0] mem [FLOWS];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               clear_busy_reg;
    logic [AW-1:0]      clear_addr_reg;

    // The clearing pass owns the write port until it reaches the last entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clear_addr_reg <= '0;
        end
        else if (clear_busy_reg)
        begin
            if (clear_addr_reg == LAST_ADDR)
            begin
                clear_busy_reg <= 1'b0;
            end
            else
            begin
                clear_addr_reg <= clear_addr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clear_busy_reg)
        begin
            mem[clear_addr_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data   = rd_data_reg;
    assign init_done = !clear_busy_reg;

endmodule

/* rtl/sliding_window_rate_limiter_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding-window log rate limiter core
// Per-flow rate limiter that keeps a ring of accepted request timestamps for
// every flow, evicts expired stamps and accepts or rejects each request.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Content
//  --------  ---------  ---------------------  ------------------------------
//  config    in         cfg_write              cfg_index, cfg_data
//  request   in         in_valid / in_ready    flow_index, now_time
//  response  out        out_valid / out_ready  allowed, remaining, retry_delay
//
// A request transaction passes through the fetch and decide states when its
// flow ring is empty, and otherwise through fetch, a check step for each stamp
// that it evicts (0 to LOG_DEPTH of them) and for the first stamp that stays,
// and decide: the eviction walk reads the stamp memory once per cycle. When
// the walk evicts every stamp of the ring it goes straight to the decision.
// After reset the flow table is swept to zero; in_ready stays low during that
// sweep, while configuration writes are taken.
// A finished response waits in the output register; the next request is
// accepted meanwhile and only stalls at its own decision step.
//
module sliding_window_rate_limiter_core #(
    parameter int unsigned FLOWS     = swrl_pkg::FLOWS_DEF,
    parameter int unsigned LOG_DEPTH = swrl_pkg::LOG_DEPTH_DEF,
    parameter int unsigned TIME_BITS = swrl_pkg::TIME_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_write,
    input  swrl_pkg::cfg_idx_t                cfg_index,
    input  logic [swrl_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [swrl_pkg::FLOW_W-1:0]       flow_index,
    input  logic [TIME_BITS-1:0]              now_time,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              allowed,
    output logic [swrl_pkg::REM_W-1:0]        remaining,
    output logic [swrl_pkg::RETRY_W-1:0]      retry_delay
);

    import swrl_pkg::*;

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int unsigned FLOW_AW     = (FLOWS > 1) ? $clog2(FLOWS) : 1;
    localparam int unsigned HEAD_W      = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int unsigned CNT_W       = $clog2(LOG_DEPTH + 1);
    localparam int unsigned ENTRY_W     = HEAD_W + CNT_W;
    localparam int unsigned STORE_DEPTH = FLOWS * LOG_DEPTH;
    localparam int unsigned ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int unsigned WIDE_W      = (TIME_BITS > WIN_W) ? TIME_BITS : WIN_W;
    localparam int unsigned LCW         = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int unsigned FLOW_SPAN   = 2 ** FLOW_W;
    localparam int unsigned PROD_W      = ADDR_W + 9;

    localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(LOG_DEPTH - 1);
    localparam logic [CNT_W:0]    DEPTH_SUM = (CNT_W + 1)'(LOG_DEPTH);
    localparam logic [LCW-1:0]    DEPTH_LIM = LCW'(LOG_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CHECK,
        ST_DECIDE
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [LIMIT_W-1:0] limit_reg;
    logic [WIN_W-1:0]   window_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= LIMIT_RST;
            window_reg <= WIN_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_REQUEST_LIMIT: limit_reg  <= cfg_data[LIMIT_W-1:0];
                REG_WINDOW_LENGTH: window_reg <= cfg_data[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow index folding: the incoming index is reduced modulo FLOWS by a
    // constant table built at elaboration.
    // ------------------------------------------------------------------
    logic [FLOW_AW-1:0] flow_fold [FLOW_SPAN];

    for (genvar g = 0; g < FLOW_SPAN; g++)
    begin : g_fold
        assign flow_fold[g] = FLOW_AW'(g % FLOWS);
    end

    logic [FLOW_AW-1:0] flow_sel;
    logic [PROD_W-1:0]  base_prod;
    logic [ADDR_W-1:0]  base_sel;

    assign flow_sel  = flow_fold[flow_index];
    assign base_prod = PROD_W'(flow_sel) * PROD_W'(LOG_DEPTH);
    assign base_sel  = base_prod[ADDR_W-1:0];

    // ------------------------------------------------------------------
    // Registers of the sequencer
    // ------------------------------------------------------------------
    state_t              state_reg,     state_next;
    logic [FLOW_AW-1:0]  flow_reg,      flow_next;
    logic [ADDR_W-1:0]   base_reg,      base_next;
    logic [TIME_BITS-1:0] now_reg,      now_next;
    logic [HEAD_W-1:0]   head_reg,      head_next;
    logic [CNT_W-1:0]    count_reg,     count_next;
    logic [TIME_BITS-1:0] gap_reg,      gap_next;
    logic                late_reg,      late_next;
    logic                out_valid_reg, out_valid_next;
    logic                allowed_reg,   allowed_next;
    logic [REM_W-1:0]    remaining_reg, remaining_next;
    logic [RETRY_W-1:0]  retry_reg,     retry_next;

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    logic                ft_rd_en;
    logic [FLOW_AW-1:0]  ft_rd_addr;
    logic [ENTRY_W-1:0]  ft_rd_data;
    logic                ft_wr_en;
    logic [ENTRY_W-1:0]  ft_wr_data;
    logic                ft_ready;
    logic [HEAD_W-1:0]   ft_head;
    logic [CNT_W-1:0]    ft_count;

    logic                st_rd_en;
    logic [ADDR_W-1:0]   st_rd_addr;
    logic [TIME_BITS-1:0] st_rd_data;
    logic                st_wr_en;
    logic [ADDR_W-1:0]   st_wr_addr;

    swrl_flow_table #(
        .FLOWS   (FLOWS),
        .ENTRY_W (ENTRY_W)
    ) u_flow_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (ft_rd_en),
        .rd_addr   (ft_rd_addr),
        .rd_data   (ft_rd_data),
        .wr_en     (ft_wr_en),
        .wr_addr   (flow_reg),
        .wr_data   (ft_wr_data),
        .init_done (ft_ready)
    );

    swrl_stamp_ram #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (TIME_BITS)
    ) u_stamp_ram (
        .clk     (clk),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (now_reg)
    );

    assign ft_head  = ft_rd_data[ENTRY_W-1:CNT_W];
    assign ft_count = ft_rd_data[CNT_W-1:0];

    // ------------------------------------------------------------------
    // Expiry test of the stamp at the ring head. A stamp later than now
    // never expires; otherwise it expires once now - stamp reaches the window.
    // ------------------------------------------------------------------
    logic                 late_c;
    logic [TIME_BITS-1:0] gap_c;
    logic                 expired_c;
    logic [HEAD_W-1:0]    head_inc;

    assign late_c    = now_reg < st_rd_data;
    assign gap_c     = late_c ? (st_rd_data - now_reg) : (now_reg - st_rd_data);
    assign expired_c = !late_c && (WIDE_W'(gap_c) >= WIDE_W'(window_reg));
    assign head_inc  = (head_reg == HEAD_LAST) ? '0 : head_reg + HEAD_W'(1);

    // ------------------------------------------------------------------
    // Decision arithmetic, from the registered head state.
    // ------------------------------------------------------------------
    logic [LCW-1:0]     limit_eff;
    logic               reject_c;
    logic [LCW-1:0]     rem_full;
    logic [WIDE_W:0]    late_sum;
    logic [WIN_W-1:0]   retry_late;
    logic [WIDE_W-1:0]  early_diff;
    logic [WIN_W-1:0]   retry_early;
    logic [RETRY_W-1:0] retry_c;
    logic [CNT_W:0]     slot_sum;
    logic [CNT_W:0]     slot_c;
    logic               out_free;

    assign limit_eff = (LCW'(limit_reg) > DEPTH_LIM) ? DEPTH_LIM : LCW'(limit_reg);
    assign reject_c  = LCW'(count_reg) >= limit_eff;
    assign rem_full  = limit_eff - LCW'(count_reg) - LCW'(1);

    // Stamp in the future: the gap plus a whole window, saturated.
    assign late_sum   = (WIDE_W + 1)'(gap_reg) + (WIDE_W + 1)'(window_reg);
    assign retry_late = (late_sum > (WIDE_W + 1)'(WIN_MAX)) ? WIN_MAX : late_sum[WIN_W-1:0];

    // Stamp in the past: the part of the window still to run. The head stamp
    // reached here has not expired, so the gap is below the window.
    assign early_diff  = WIDE_W'(window_reg) - WIDE_W'(gap_reg);
    assign retry_early = early_diff[WIN_W-1:0];

    assign retry_c = (count_reg == '0) ? '0 : (late_reg ? retry_late : retry_early);

    // Slot for the new stamp: (head + count) wrapped at the ring depth.
    assign slot_sum = (CNT_W + 1)'(head_reg) + (CNT_W + 1)'(count_reg);
    assign slot_c   = (slot_sum >= DEPTH_SUM) ? (slot_sum - DEPTH_SUM) : slot_sum;

    assign out_free = !out_valid_reg || out_ready;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        flow_next      = flow_reg;
        base_next      = base_reg;
        now_next       = now_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        gap_next       = gap_reg;
        late_next      = late_reg;
        out_valid_next = out_valid_reg && !out_ready;
        allowed_next   = allowed_reg;
        remaining_next = remaining_reg;
        retry_next     = retry_reg;

        ft_rd_en   = 1'b0;
        ft_rd_addr = flow_sel;
        ft_wr_en   = 1'b0;
        ft_wr_data = {head_reg, count_reg};
        st_rd_en   = 1'b0;
        st_rd_addr = base_reg + ADDR_W'(head_reg);
        st_wr_en   = 1'b0;
        st_wr_addr = base_reg + ADDR_W'(slot_c[HEAD_W-1:0]);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && ft_ready)
                begin
                    flow_next  = flow_sel;
                    base_next  = base_sel;
                    now_next   = now_time;
                    ft_rd_en   = 1'b1;
                    state_next = ST_FETCH;
                end
            end

            ST_FETCH:
            begin
                head_next = ft_head;
                count_next = ft_count;
                if (ft_count != '0)
                begin
                    st_rd_en   = 1'b1;
                    st_rd_addr = base_reg + ADDR_W'(ft_head);
                    state_next = ST_CHECK;
                end
                else
                begin
                    state_next = ST_DECIDE;
                end
            end

            ST_CHECK:
            begin
                if (expired_c)
                begin
                    // Drop the oldest stamp and look at the next one, if any.
                    head_next  = head_inc;
                    count_next = count_reg - CNT_W'(1);
                    if (count_reg > CNT_W'(1))
                    begin
                        st_rd_en   = 1'b1;
                        st_rd_addr = base_reg + ADDR_W'(head_inc);
                    end
                    else
                    begin
                        state_next = ST_DECIDE;
                    end
                end
                else
                begin
                    gap_next   = gap_c;
                    late_next  = late_c;
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                if (out_free)
                begin
                    ft_wr_en       = 1'b1;
                    out_valid_next = 1'b1;
                    if (reject_c)
                    begin
                        allowed_next   = 1'b0;
                        remaining_next = '0;
                        retry_next     = retry_c;
                    end
                    else
                    begin
                        st_wr_en       = 1'b1;
                        ft_wr_data     = {head_reg, count_reg + CNT_W'(1)};
                        allowed_next   = 1'b1;
                        remaining_next = rem_full[REM_W-1:0];
                        retry_next     = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            flow_reg      <= flow_next;
            base_reg      <= base_next;
            now_reg       <= now_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            gap_reg       <= gap_next;
            late_reg      <= late_next;
            allowed_reg   <= allowed_next;
            remaining_reg <= remaining_next;
            retry_reg     <= retry_next;
        end
    end

    assign in_ready    = (state_reg == ST_IDLE) && ft_ready;
    assign out_valid   = out_valid_reg;
    assign allowed     = allowed_reg;
    assign remaining   = remaining_reg;
    assign retry_delay = retry_reg;

endmodule

/* bench/rate_decision_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rate limiter decision checker
// Watches the configuration port and both channels of the rate limiter core.
// It keeps its own copy of the per-flow stamp rings and the limit and window
// settings, predicts the verdict of every accepted request and compares it
// with each response transaction in order.
// ----------------------------------------------------------------------------
module rate_decision_checker (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_write,
    input  swrl_pkg::cfg_idx_t                  cfg_index,
    input  logic [swrl_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic [swrl_pkg::FLOW_W-1:0]         flow_index,
    input  logic [swrl_pkg::TIME_BITS_DEF-1:0]  now_time,

    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic                                allowed,
    input  logic [swrl_pkg::REM_W-1:0]          remaining,
    input  logic [swrl_pkg::RETRY_W-1:0]        retry_delay,

    output int                                  mismatch_total,
    output int                                  verdicts_pending,
    output int                                  allow_total,
    output int                                  deny_total
);

    import swrl_pkg::*;

    localparam int unsigned FLOW_N = FLOWS_DEF;
    localparam int unsigned DEPTH  = LOG_DEPTH_DEF;
    localparam int unsigned TW     = TIME_BITS_DEF;
    localparam int unsigned SLOT_W = $clog2(DEPTH);

    typedef struct packed {
        logic               allowed;
        logic [REM_W-1:0]   remaining;
        logic [RETRY_W-1:0] retry_delay;
    } verdict_t;

    logic [TW-1:0]      stamp_log  [FLOW_N][DEPTH];
    logic [SLOT_W-1:0]  ring_start [FLOW_N];
    logic [LIMIT_W-1:0] ring_fill  [FLOW_N];
    logic [LIMIT_W-1:0] limit_reg;
    logic [WIN_W-1:0]   window_reg;
    verdict_t           verdict_q [$];
    int                 errs;
    int                 n_allow;
    int                 n_deny;

    function automatic bit stamp_expired(input logic [TW-1:0] stamp, input logic [TW-1:0] now);
        return (now >= stamp) && ((now - stamp) >= {{(TW-WIN_W){1'b0}}, window_reg});
    endfunction

    // Time until the oldest stamp leaves the window. A stamp in the future
    // adds its distance to the full window, saturating at the field maximum.
    function automatic logic [RETRY_W-1:0] expiry_delay(input logic [TW-1:0] stamp,
                                                        input logic [TW-1:0] now);
        logic [63:0] gap;
        logic [63:0] sum;
        if (now < stamp)
        begin
            gap = 64'(stamp - now);
            sum = gap + 64'(window_reg);
            return (sum > 64'(WIN_MAX)) ? WIN_MAX : sum[RETRY_W-1:0];
        end
        gap = 64'(now - stamp);
        return (gap >= 64'(window_reg)) ? '0 : window_reg - gap[RETRY_W-1:0];
    endfunction

    function automatic verdict_t judge_request(input logic [FLOW_W-1:0] flow,
                                               input logic [TW-1:0] now);
        verdict_t          v;
        logic [SLOT_W-1:0] head;
        logic [SLOT_W-1:0] slot;
        logic [LIMIT_W-1:0] cnt;
        logic [LIMIT_W-1:0] cap;
        head = ring_start[flow];
        cnt  = ring_fill[flow];
        cap  = (limit_reg > LIMIT_W'(DEPTH)) ? LIMIT_W'(DEPTH) : limit_reg;
        while (cnt != 0 && stamp_expired(stamp_log[flow][head], now))
        begin
            head = head + SLOT_W'(1);
            cnt  = cnt - LIMIT_W'(1);
        end
        ring_start[flow] = head;
        ring_fill[flow]  = cnt;
        v = '0;
        if (cnt >= cap)
        begin
            if (cnt != 0)
                v.retry_delay = expiry_delay(stamp_log[flow][head], now);
        end
        else
        begin
            slot = head + cnt[SLOT_W-1:0];
            stamp_log[flow][slot] = now;
            ring_fill[flow] = cnt + LIMIT_W'(1);
            v.allowed   = 1'b1;
            v.remaining = cap - cnt - LIMIT_W'(1);
        end
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        verdict_t got;
        if (!rst_n)
        begin
            for (int f = 0; f < FLOW_N; f++)
            begin
                ring_start[f] = '0;
                ring_fill[f]  = '0;
                for (int s = 0; s < DEPTH; s++)
                    stamp_log[f][s] = '0;
            end
            limit_reg  = LIMIT_RST;
            window_reg = WIN_RST;
            verdict_q.delete();
            errs    = 0;
            n_allow = 0;
            n_deny  = 0;
            mismatch_total   <= 0;
            verdicts_pending <= 0;
            allow_total      <= 0;
            deny_total       <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_REQUEST_LIMIT: limit_reg  = cfg_data[LIMIT_W-1:0];
                    REG_WINDOW_LENGTH: window_reg = cfg_data[WIN_W-1:0];
                    default: ;
                endcase
            end

            if (out_valid && out_ready)
            begin
                got = {allowed, remaining, retry_delay};
                if (verdict_q.size() == 0)
                begin
                    errs++;
                    $display({"%0t ns: unexpected response, expected none, ",
                              "got allowed=%0b remaining=%0d retry_delay=%0d"},
                             $time, got.allowed, got.remaining, got.retry_delay);
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (want.allowed)
                        n_allow++;
                    else
                        n_deny++;
                    if (got !== want)
                    begin
                        errs++;
                        $display({"%0t ns: response mismatch, expected allowed=%0b ",
                                  "remaining=%0d retry_delay=%0d, got allowed=%0b ",
                                  "remaining=%0d retry_delay=%0d"},
                                 $time, want.allowed, want.remaining, want.retry_delay,
                                 got.allowed, got.remaining, got.retry_delay);
                    end
                end
            end

            if (in_valid && in_ready)
                verdict_q.push_back(judge_request(flow_index, now_time));

            mismatch_total   <= errs;
            verdicts_pending <= verdict_q.size();
            allow_total      <= n_allow;
            deny_total       <= n_deny;
        end
    end

endmodule

/* bench/tb_sliding_window_rate_limiter_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding-window rate limiter core testbench
// Drives request transactions and register writes into the core, with random
// stalls on both channels, while a checker beside the core predicts and
// compares every response. A short directed part hits the window boundary,
// zero limit, zero window, oversized limit and time running backwards; a long
// random part then walks through several limit and window settings.
// ----------------------------------------------------------------------------
module tb_sliding_window_rate_limiter_core;

    import swrl_pkg::*;

    localparam int unsigned TW = TIME_BITS_DEF;

    // Clock, reset and every block input start at known values.
    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_write   = 1'b0;
    cfg_idx_t              cfg_index   = REG_REQUEST_LIMIT;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  in_valid    = 1'b0;
    logic [FLOW_W-1:0]     flow_index  = '0;
    logic [TW-1:0]         now_time    = '0;
    logic                  out_ready   = 1'b0;

    logic                  in_ready;
    logic                  out_valid;
    logic                  allowed;
    logic [REM_W-1:0]      remaining;
    logic [RETRY_W-1:0]    retry_delay;

    int                    mismatch_total;
    int                    verdicts_pending;
    int                    allow_total;
    int                    deny_total;

    // Stall control shared by both sides. The percentage is reshuffled every
    // few dozen transactions so that stretches without any stall occur too;
    // once the quiet tail starts neither side stalls again.
    int                    idle_pct     = 20;
    bit                    quiet_tail   = 1'b0;
    int                    ready_hold   = 0;

    // Last time stamp sent on each flow and the window currently programmed,
    // used to place new stamps relative to the window.
    logic [TW-1:0]         flow_clock [FLOWS_DEF];
    logic [WIN_W-1:0]      cur_window   = WIN_RST;
    int                    settings_run = 0;

    // Random phases: each one programs a limit and a window, then sends its
    // share of requests. The set covers the reset values, a zero limit, a
    // zero window, a one-microsecond window, the widest window and a limit
    // beyond the log depth.
    localparam int N_PHASES = 7;
    int               phase_items  [N_PHASES] = '{300, 300, 250, 150, 150, 200, 600};
    logic [LIMIT_W-1:0] phase_limit [N_PHASES] = '{LIMIT_RST, 5'd16, 5'd31, 5'd0,
                                                   5'd1, 5'd4, 5'd3};
    logic [WIN_W-1:0]   phase_window[N_PHASES] = '{WIN_RST, 36'd1000, WIN_MAX, 36'd5000,
                                                   36'd0, 36'd1, 36'd100000};

    sliding_window_rate_limiter_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .flow_index  (flow_index),
        .now_time    (now_time),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .allowed     (allowed),
        .remaining   (remaining),
        .retry_delay (retry_delay)
    );

    rate_decision_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .flow_index       (flow_index),
        .now_time         (now_time),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .allowed          (allowed),
        .remaining        (remaining),
        .retry_delay      (retry_delay),
        .mismatch_total   (mismatch_total),
        .verdicts_pending (verdicts_pending),
        .allow_total      (allow_total),
        .deny_total       (deny_total)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Response side back-pressure: a burst drops out_ready and holds it low while ready_hold counts down.
    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
        end
        else if (rst_n && !quiet_tail && $urandom_range(0, 99) < idle_pct)
        begin
            out_ready  <= 1'b0;
            ready_hold <= $urandom_range(0, 6);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Both registers are written back to back; callers make sure the core
    // has delivered every response first, so it is idle during the write.
    task automatic program_limits(input logic [LIMIT_W-1:0] lim, input logic [WIN_W-1:0] win);
        cfg_write <= 1'b1;
        cfg_index <= REG_REQUEST_LIMIT;
        cfg_data  <= CFG_DATA_W'(lim);
        @(posedge clk);
        cfg_index <= REG_WINDOW_LENGTH;
        cfg_data  <= CFG_DATA_W'(win);
        @(posedge clk);
        cfg_write  <= 1'b0;
        cur_window  = win;
        settings_run++;
    endtask

    // Lowers in_valid and waits until the checker has nothing outstanding.
    // The first edge is always taken, so a request accepted on the calling
    // edge is already counted when pending is looked at.
    task automatic drain_responses();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (verdicts_pending != 0);
    endtask

    // One request transaction. An optional gap with in_valid low comes first;
    // without a gap valid simply stays high into the next transaction.
    task automatic send_request(input logic [FLOW_W-1:0] flow, input logic [TW-1:0] stamp);
        if (!quiet_tail && $urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        flow_index <= flow;
        now_time   <= stamp;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Random request: most traffic lands on eight busy flows so the rings
    // fill up and evict. Time moves forward by a fraction of the window,
    // sometimes exactly to the expiry edge of the newest stamp or one short
    // of it, sometimes not at all, and now and then slightly backwards.
    task automatic random_request();
        logic [FLOW_W-1:0] flow;
        logic [TW-1:0]     stamp;
        logic [63:0]       span;
        logic [63:0]       step;
        int                pick;
        flow = ($urandom_range(0, 9) < 7) ? FLOW_W'($urandom_range(0, 7))
                                          : FLOW_W'($urandom_range(0, FLOWS_DEF - 1));
        span = 64'(cur_window);
        pick = $urandom_range(0, 99);
        if (pick < 4)
            stamp = flow_clock[flow] - TW'($urandom_range(1, 1000));
        else if (pick < 10)
            stamp = flow_clock[flow] + span[TW-1:0];
        else if (pick < 14)
            stamp = flow_clock[flow] + span[TW-1:0] - 1'b1;
        else if (pick < 24)
            stamp = flow_clock[flow];
        else
        begin
            step  = {$urandom, $urandom} % (span / 4 + 1);
            stamp = flow_clock[flow] + step[TW-1:0];
        end
        flow_clock[flow] = stamp;
        send_request(flow, stamp);
    endtask

    initial
    begin
        logic [63:0] seed_word;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. Limit 2, window 100: fill a ring, get refused one
        // microsecond before the oldest stamp expires, then hit the exact
        // expiry edge where the stamp is evicted.
        program_limits(5'd2, 36'd100);
        send_request(6'd0, 48'd0);
        send_request(6'd0, 48'd50);
        send_request(6'd0, 48'd99);
        send_request(6'd0, 48'd100);
        send_request(6'd0, 48'd100);
        // Largest flow and largest time, then time jumping backwards so the
        // oldest stamp lies in the future and the retry delay saturates.
        send_request(6'd63, 48'hFFFF_FFFF_FFFF);
        send_request(6'd63, 48'd10);
        send_request(6'd63, 48'd10);
        send_request(6'd42, 48'hAAAA_AAAA_AAAA);
        send_request(6'd21, 48'h5555_5555_5555);
        // Zero limit: an empty flow is refused with no delay, a flow with
        // live stamps is refused with the time left on its oldest one.
        drain_responses();
        program_limits(5'd0, 36'd100);
        send_request(6'd5, 48'd7);
        send_request(6'd0, 48'd120);
        // Zero window: every stamp at or before now goes away at once, but a
        // stamp in the future still blocks the flow.
        drain_responses();
        program_limits(5'd1, 36'd0);
        send_request(6'd0, 48'd120);
        send_request(6'd0, 48'd120);
        send_request(6'd63, 48'd5);
        // A limit above the log depth behaves as the depth.
        drain_responses();
        program_limits(5'd31, WIN_MAX);
        send_request(6'd9, 48'd0);

        // Per-flow clocks start at full-width random values on about half
        // the flows so the upper time bits toggle.
        for (int f = 0; f < FLOWS_DEF; f++)
        begin
            seed_word     = {$urandom, $urandom};
            flow_clock[f] = $urandom_range(0, 1) ? seed_word[TW-1:0]
                                                 : TW'($urandom_range(0, 1000));
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            drain_responses();
            program_limits(phase_limit[p], phase_window[p]);
            for (int k = 0; k < phase_items[p]; k++)
            begin
                if (k % 64 == 0)
                begin
                    case ($urandom_range(0, 2))
                        0: idle_pct = 0;
                        1: idle_pct = 12;
                        default: idle_pct = 35;
                    endcase
                end
                if (p == N_PHASES - 1 && k == phase_items[p] - 250)
                    quiet_tail = 1'b1;
                // Hold the sender once until the core has emptied out.
                if (p == 0 && k == phase_items[p] / 2)
                    drain_responses();
                random_request();
            end
        end

        drain_responses();
        repeat (40) @(posedge clk);

        $display({"Covered %0d requests (%0d allowed, %0d refused) ",
                  "under %0d limit/window settings,"},
                 allow_total + deny_total, allow_total, deny_total, settings_run);
        $display("including zero limit, zero window, widest window and backwards time.");
        if (mismatch_total == 0 && verdicts_pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Safety net far beyond the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* sim.f */
rtl/swrl_pkg.sv
rtl/swrl_stamp_ram.sv
rtl/swrl_flow_table.sv
rtl/sliding_window_rate_limiter_core.sv
bench/rate_decision_checker.sv
bench/tb_sliding_window_rate_limiter_core.sv
